### src/prb_pkg.sv
package prb_pkg;

  localparam int IN_BITS    = 16;
  localparam int COORD_BITS = 16;
  localparam int COEF_BITS  = 32;
  localparam int NUM_COEF   = 9;
  localparam int NUM_CORNER = 4;
  localparam int CW         = IN_BITS + 2;
  localparam int PP         = COEF_BITS + CW;
  localparam int PW         = PP + 2;
  localparam int RW         = PW + COORD_BITS;
  localparam int FW         = COORD_BITS + 2;
  localparam int DIV_LAT    = COORD_BITS + 3;
  localparam int ADDR_BITS  = 6;
  localparam int DATA_BITS  = 64;
  localparam int Q_DEPTH    = 2;

  localparam logic [2:0] REG_ROW0_AB       = 3'd0;
  localparam logic [2:0] REG_ROW0_C_ROW1_A = 3'd1;
  localparam logic [2:0] REG_ROW1_BC       = 3'd2;
  localparam logic [2:0] REG_ROW2_AB       = 3'd3;
  localparam logic [2:0] REG_ROW2_C        = 3'd4;

  typedef struct packed {
    logic                 empty;
    logic signed [CW-1:0] cx0;
    logic signed [CW-1:0] cx1;
    logic signed [CW-1:0] cy0;
    logic signed [CW-1:0] cy1;
  } item_t;

  typedef logic [NUM_COEF-1:0][COEF_BITS-1:0] coefs_t;

endpackage

### src/prb_front.sv
module prb_front (
  input  logic signed [prb_pkg::IN_BITS-1:0] rect_x,
  input  logic signed [prb_pkg::IN_BITS-1:0] rect_y,
  input  logic        [prb_pkg::IN_BITS-1:0] rect_width,
  input  logic        [prb_pkg::IN_BITS-1:0] rect_height,
  output prb_pkg::item_t                     item
);

  // corners of the source rectangle and the empty check
  always_comb begin
    item.empty = (rect_width == '0) || (rect_height == '0);
    item.cx0   = prb_pkg::CW'(rect_x);
    item.cy0   = prb_pkg::CW'(rect_y);
    item.cx1   = prb_pkg::CW'(rect_x) + $signed({2'b00, rect_width});
    item.cy1   = prb_pkg::CW'(rect_y) + $signed({2'b00, rect_height});
  end

endmodule

### src/prb_queue.sv
module prb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prb_pkg::item_t push_item,
  input  logic           pop,
  output prb_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  prb_pkg::item_t mem_r [prb_pkg::Q_DEPTH];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(prb_pkg::Q_DEPTH));
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

### src/prb_div.sv
module prb_div (
  input  logic                              clk,
  input  logic signed [prb_pkg::PW-1:0]     n_i,
  input  logic signed [prb_pkg::PW-1:0]     d_i,
  output logic signed [prb_pkg::FW-1:0]     fl_o,
  output logic signed [prb_pkg::FW-1:0]     cl_o,
  output logic                              bad_o
);

  localparam int QB = prb_pkg::COORD_BITS;
  localparam int PW = prb_pkg::PW;
  localparam int RW = prb_pkg::RW;
  localparam int FW = prb_pkg::FW;

  logic [PW-1:0] an_r, ad_r;
  logic          neg_r, dz_r;

  logic [RW-1:0] rem_r [QB+1];
  logic [RW-1:0] dv_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          sg_r  [QB+1];
  logic          bd_r  [QB+1];

  logic [RW:0]   trial [QB];
  logic [FW-1:0] qx;
  logic          rnz;

  always_ff @(posedge clk) begin
    an_r  <= n_i[PW-1] ? PW'(-n_i) : PW'(n_i);
    ad_r  <= d_i[PW-1] ? PW'(-d_i) : PW'(d_i);
    neg_r <= n_i[PW-1] ^ d_i[PW-1];
    dz_r  <= (d_i == '0);
  end

  // quotient beyond the output range, or a zero divisor, is flagged here
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(an_r);
    dv_r[0]  <= RW'(ad_r);
    q_r[0]   <= '0;
    sg_r[0]  <= neg_r;
    bd_r[0]  <= dz_r || (RW'(an_r) >= (RW'(ad_r) << QB));
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {1'b0, rem_r[k]} - {1'b0, dv_r[k] << (QB - 1 - k)};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      rem_r[k+1] <= trial[k][RW] ? rem_r[k] : trial[k][RW-1:0];
      q_r[k+1]   <= {q_r[k][QB-2:0], ~trial[k][RW]};
      dv_r[k+1]  <= dv_r[k];
      sg_r[k+1]  <= sg_r[k];
      bd_r[k+1]  <= bd_r[k];
    end
  end

  assign qx  = {2'b00, q_r[QB]};
  assign rnz = (rem_r[QB] != '0);

  always_ff @(posedge clk) begin
    if (sg_r[QB]) begin
      fl_o <= $signed(-qx - FW'(rnz));
      cl_o <= $signed(-qx);
    end else begin
      fl_o <= $signed(qx);
      cl_o <= $signed(qx + FW'(rnz));
    end
    bad_o <= bd_r[QB];
  end

endmodule

### src/prb_back.sv
module prb_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop,
  input  prb_pkg::item_t                        item,
  input  prb_pkg::coefs_t                       coefs,
  output logic                                  out_strobe,
  output logic signed [prb_pkg::COORD_BITS-1:0] out_x,
  output logic signed [prb_pkg::COORD_BITS-1:0] out_y,
  output logic        [prb_pkg::COORD_BITS-1:0] out_width,
  output logic        [prb_pkg::COORD_BITS-1:0] out_height,
  output logic                                  out_valid
);

  localparam int NC  = prb_pkg::NUM_CORNER;
  localparam int PP  = prb_pkg::PP;
  localparam int PW  = prb_pkg::PW;
  localparam int FW  = prb_pkg::FW;
  localparam int QB  = prb_pkg::COORD_BITS;
  localparam int CW  = prb_pkg::CW;
  localparam int DL  = prb_pkg::DIV_LAT;
  localparam int VL  = DL + 2;
  localparam int TOT = DL + 4;
  localparam logic signed [FW-1:0] LO = FW'(-(2 ** (QB - 1)));
  localparam logic signed [FW-1:0] HI = FW'((2 ** (QB - 1)) - 1);

  logic signed [CW-1:0] cx [NC];
  logic signed [CW-1:0] cy [NC];
  logic signed [PP-1:0] p_r [NC][6];
  logic signed [PW-1:0] nx_r [NC];
  logic signed [PW-1:0] ny_r [NC];
  logic signed [PW-1:0] d_r  [NC];

  logic signed [FW-1:0] flx [NC];
  logic signed [FW-1:0] clx [NC];
  logic signed [FW-1:0] fly [NC];
  logic signed [FW-1:0] cly [NC];
  logic                 bdx [NC];
  logic                 bdy [NC];

  logic [VL-1:0] vld_r, vld_nxt;
  logic [VL-1:0] emp_r;

  logic                 red_vld_r;
  logic                 red_bad_r;
  logic signed [FW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [FW-1:0] x0_c, y0_c, x1_c, y1_c;
  logic                 bad_c;

  logic signed [FW-1:0] wd, ht;
  logic                 ok;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cx[k] = k[0] ? item.cx1 : item.cx0;
      cy[k] = k[1] ? item.cy1 : item.cy0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      p_r[k][0] <= $signed(coefs[0]) * cx[k];
      p_r[k][1] <= $signed(coefs[1]) * cy[k];
      p_r[k][2] <= $signed(coefs[3]) * cx[k];
      p_r[k][3] <= $signed(coefs[4]) * cy[k];
      p_r[k][4] <= $signed(coefs[6]) * cx[k];
      p_r[k][5] <= $signed(coefs[7]) * cy[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      nx_r[k] <= PW'(p_r[k][0]) + PW'(p_r[k][1]) + PW'($signed(coefs[2]));
      ny_r[k] <= PW'(p_r[k][2]) + PW'(p_r[k][3]) + PW'($signed(coefs[5]));
      d_r[k]  <= PW'(p_r[k][4]) + PW'(p_r[k][5]) + PW'($signed(coefs[8]));
    end
  end

  for (genvar g = 0; g < NC; g++) begin : g_corner
    prb_div u_div_x (
      .clk  (clk),
      .n_i  (nx_r[g]),
      .d_i  (d_r[g]),
      .fl_o (flx[g]),
      .cl_o (clx[g]),
      .bad_o(bdx[g])
    );
    prb_div u_div_y (
      .clk  (clk),
      .n_i  (ny_r[g]),
      .d_i  (d_r[g]),
      .fl_o (fly[g]),
      .cl_o (cly[g]),
      .bad_o(bdy[g])
    );
  end

  assign vld_nxt = {vld_r[VL-2:0], pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      red_vld_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      red_vld_r  <= vld_r[VL-1];
      out_strobe <= red_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    emp_r <= {emp_r[VL-2:0], item.empty};
  end

  // min of floors and max of ceilings over the four corners, and OR of the bad flags
  always_comb begin
    x0_c  = flx[0];
    y0_c  = fly[0];
    x1_c  = clx[0];
    y1_c  = cly[0];
    bad_c = emp_r[VL-1] || bdx[0] || bdy[0];
    for (int k = 1; k < NC; k++) begin
      if (flx[k] < x0_c) x0_c = flx[k];
      if (fly[k] < y0_c) y0_c = fly[k];
      if (clx[k] > x1_c) x1_c = clx[k];
      if (cly[k] > y1_c) y1_c = cly[k];
      bad_c = bad_c || bdx[k] || bdy[k];
    end
  end

  always_ff @(posedge clk) begin
    x0_r      <= x0_c;
    y0_r      <= y0_c;
    x1_r      <= x1_c;
    y1_r      <= y1_c;
    red_bad_r <= bad_c;
  end

  always_comb begin
    wd = x1_r - x0_r;
    ht = y1_r - y0_r;
    ok = !red_bad_r && (x1_r > x0_r) && (y1_r > y0_r) &&
         (x0_r >= LO) && (y0_r >= LO) && (x1_r <= HI) && (y1_r <= HI);
  end

  always_ff @(posedge clk) begin
    out_valid  <= ok;
    out_x      <= ok ? x0_r[QB-1:0] : '0;
    out_y      <= ok ? y0_r[QB-1:0] : '0;
    out_width  <= ok ? wd[QB-1:0] : '0;
    out_height <= ok ? ht[QB-1:0] : '0;
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid |-> out_x == '0 && out_y == '0 &&
                                 out_width == '0 && out_height == '0)
    else $error("rejected result carries nonzero fields");

  a_valid_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid |-> out_width != '0 && out_height != '0)
    else $error("valid result with zero extent");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> ##TOT out_strobe)
    else $error("transfer lost in back pipeline");

endmodule

### src/projective_rect_bound.sv
// Bounding box of a pixel rectangle under a 3x3 projective transform held in
// Q16.16 coefficient registers (reset: identity). Pulse start with the four
// rectangle fields while busy is low; one result appears on the out_ ports
// for a single cycle with out_strobe for each rectangle taken. The receiver
// cannot stall: the back pipeline never holds off, so a new rectangle can
// be taken every clock and busy stays low in normal use. The radix-2
// dividers give one quotient bit per stage, eight of them working in
// parallel on the four corners. Write the coefficient registers only while
// no transfer is in flight.
module projective_rect_bound (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [prb_pkg::IN_BITS-1:0]    in_rect_x,
  input  logic signed [prb_pkg::IN_BITS-1:0]    in_rect_y,
  input  logic        [prb_pkg::IN_BITS-1:0]    in_rect_width,
  input  logic        [prb_pkg::IN_BITS-1:0]    in_rect_height,
  output logic                                  out_strobe,
  output logic signed [prb_pkg::COORD_BITS-1:0] out_x,
  output logic signed [prb_pkg::COORD_BITS-1:0] out_y,
  output logic        [prb_pkg::COORD_BITS-1:0] out_width,
  output logic        [prb_pkg::COORD_BITS-1:0] out_height,
  output logic                                  out_valid,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [prb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic        [prb_pkg::DATA_BITS-1:0]  pwdata,
  output logic        [prb_pkg::DATA_BITS-1:0]  prdata,
  output logic                                  pready
);

  logic [63:0] row0_ab_r, row0_c_row1_a_r, row1_bc_r, row2_ab_r;
  logic [31:0] row2_c_r;
  logic [2:0]  idx;
  logic        wr;

  prb_pkg::item_t  f_item, q_head;
  prb_pkg::coefs_t coefs;
  logic            q_empty, q_full, push, pop;

  assign pready = 1'b1;
  assign idx    = paddr[prb_pkg::ADDR_BITS-1:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_ab_r       <= 64'h0001_0000_0000_0000;
      row0_c_row1_a_r <= '0;
      row1_bc_r       <= 64'h0001_0000_0000_0000;
      row2_ab_r       <= '0;
      row2_c_r        <= 32'h0001_0000;
    end else if (wr) begin
      unique case (idx)
        prb_pkg::REG_ROW0_AB:       row0_ab_r       <= pwdata;
        prb_pkg::REG_ROW0_C_ROW1_A: row0_c_row1_a_r <= pwdata;
        prb_pkg::REG_ROW1_BC:       row1_bc_r       <= pwdata;
        prb_pkg::REG_ROW2_AB:       row2_ab_r       <= pwdata;
        prb_pkg::REG_ROW2_C:        row2_c_r        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      prb_pkg::REG_ROW0_AB:       prdata = row0_ab_r;
      prb_pkg::REG_ROW0_C_ROW1_A: prdata = row0_c_row1_a_r;
      prb_pkg::REG_ROW1_BC:       prdata = row1_bc_r;
      prb_pkg::REG_ROW2_AB:       prdata = row2_ab_r;
      prb_pkg::REG_ROW2_C:        prdata = {32'h0, row2_c_r};
      default:                    prdata = '0;
    endcase
  end

  assign coefs = {row2_c_r,
                  row2_ab_r[31:0], row2_ab_r[63:32],
                  row1_bc_r[31:0], row1_bc_r[63:32],
                  row0_c_row1_a_r[31:0], row0_c_row1_a_r[63:32],
                  row0_ab_r[31:0], row0_ab_r[63:32]};

  assign busy = q_full;
  assign push = start && !busy;
  assign pop  = !q_empty;

  prb_front u_front (
    .rect_x     (in_rect_x),
    .rect_y     (in_rect_y),
    .rect_width (in_rect_width),
    .rect_height(in_rect_height),
    .item       (f_item)
  );

  prb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(f_item),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  prb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .item      (q_head),
    .coefs     (coefs),
    .out_strobe(out_strobe),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_width (out_width),
    .out_height(out_height),
    .out_valid (out_valid)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int IN_BITS    = prb_pkg::IN_BITS;
  localparam int COORD_BITS = prb_pkg::COORD_BITS;
  localparam int ADDR_BITS  = prb_pkg::ADDR_BITS;
  localparam int DATA_BITS  = prb_pkg::DATA_BITS;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0]        w;
    logic [COORD_BITS-1:0]        h;
    logic                         v;
  } bound_t;

  class rect_scoreboard;
    logic [DATA_BITS-1:0] coef_reg [5];
    bound_t               pending [$];
    int                   mismatches;

    function new();
      coef_reg[prb_pkg::REG_ROW0_AB]       = 64'h0001_0000_0000_0000;
      coef_reg[prb_pkg::REG_ROW0_C_ROW1_A] = 64'h0;
      coef_reg[prb_pkg::REG_ROW1_BC]       = 64'h0001_0000_0000_0000;
      coef_reg[prb_pkg::REG_ROW2_AB]       = 64'h0;
      coef_reg[prb_pkg::REG_ROW2_C]        = 64'h0000_0000_0001_0000;
      mismatches = 0;
    endfunction

    function void set_coef(int idx, logic [DATA_BITS-1:0] val);
      if (idx == prb_pkg::REG_ROW2_C) coef_reg[idx] = {32'h0, val[31:0]};
      else if (idx < 5) coef_reg[idx] = val;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q, r;
      q = n / d;
      r = n % d;
      if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
      return q;
    endfunction

    // bounding box of the mapped corners
    function void note_rect(logic signed [IN_BITS-1:0] rx,
                            logic signed [IN_BITS-1:0] ry,
                            logic [IN_BITS-1:0] rw, logic [IN_BITS-1:0] rh);
      longint m [9];
      longint cx, cy, d, nx, ny, fx, fy, gx, gy, x0, y0, x1, y1, lo, hi;
      bit ok;
      bound_t e;
      for (int i = 0; i < 4; i++) begin
        m[2*i]   = longint'($signed(coef_reg[i][63:32]));
        m[2*i+1] = longint'($signed(coef_reg[i][31:0]));
      end
      m[8] = longint'($signed(coef_reg[prb_pkg::REG_ROW2_C][31:0]));
      lo = -(longint'(1) << (COORD_BITS - 1));
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      ok = (rw != 0) && (rh != 0);
      x0 = 0; y0 = 0; x1 = 0; y1 = 0;
      for (int k = 0; k < 4 && ok; k++) begin
        cx = longint'(rx) + ((k & 1) ? longint'(rw) : 0);
        cy = longint'(ry) + ((k & 2) ? longint'(rh) : 0);
        d  = m[6] * cx + m[7] * cy + m[8];
        nx = m[0] * cx + m[1] * cy + m[2];
        ny = m[3] * cx + m[4] * cy + m[5];
        if (d == 0) begin
          ok = 0;
        end else begin
          fx = floor_div(nx, d);
          fy = floor_div(ny, d);
          gx = -floor_div(-nx, d);
          gy = -floor_div(-ny, d);
          if (k == 0 || fx < x0) x0 = fx;
          if (k == 0 || fy < y0) y0 = fy;
          if (k == 0 || gx > x1) x1 = gx;
          if (k == 0 || gy > y1) y1 = gy;
        end
      end
      if (ok && (x1 <= x0 || y1 <= y0 || x0 < lo || y0 < lo || x1 > hi || y1 > hi)) ok = 0;
      if (ok) begin
        e.x = x0[COORD_BITS-1:0];
        e.y = y0[COORD_BITS-1:0];
        e.w = COORD_BITS'(x1 - x0);
        e.h = COORD_BITS'(y1 - y0);
        e.v = 1'b1;
      end else begin
        e.x = '0; e.y = '0; e.w = '0; e.h = '0; e.v = 1'b0;
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_bound(bound_t got);
      bound_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.w !== e.w || got.h !== e.h
          || got.v !== e.v) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: exp x=%0d y=%0d w=%0d h=%0d v=%0b, ",
                    "got x=%0d y=%0d w=%0d h=%0d v=%0b"},
                   $realtime, e.x, e.y, e.w, e.h, e.v, got.x, got.y, got.w, got.h, got.v);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_BITS-1:0] in_rect_x = '0;
  logic signed [IN_BITS-1:0] in_rect_y = '0;
  logic [IN_BITS-1:0] in_rect_width = '0;
  logic [IN_BITS-1:0] in_rect_height = '0;
  logic out_strobe;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_width;
  logic [COORD_BITS-1:0] out_height;
  logic out_valid;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  rect_scoreboard sb = new();

  projective_rect_bound i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_rect_x(in_rect_x), .in_rect_y(in_rect_y),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_strobe(out_strobe), .out_x(out_x), .out_y(out_y),
    .out_width(out_width), .out_height(out_height), .out_valid(out_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    bound_t got;
    if (rst_n && out_strobe) begin
      got.x = out_x; got.y = out_y; got.w = out_width; got.h = out_height;
      got.v = out_valid;
      sb.check_bound(got);
    end
  end

  task automatic send_rect(logic [15:0] rx, logic [15:0] ry, logic [15:0] rw,
                           logic [15:0] rh, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_rect_x <= rx;
    in_rect_y <= ry;
    in_rect_width <= rw;
    in_rect_height <= rh;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_rect(rx, ry, rw, rh);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (COORD_BITS + 12) @(posedge clk);
  endtask

  task automatic write_coef(int idx, logic [DATA_BITS-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_coef(idx, val);
  endtask

  function automatic logic [31:0] q16(int ip, int frac);
    return (ip <<< 16) + frac;
  endfunction

  // style: 0 near-identity, 1 perspective, 2 wild, 3 singular-prone
  task automatic load_matrix(int style);
    logic [31:0] m [9];
    for (int i = 0; i < 9; i++) m[i] = $urandom;
    case (style)
      0: begin
        m[0] = q16($urandom_range(0, 3), $urandom_range(0, 65535)) * (($urandom & 1) ? 1 : -1);
        m[1] = $signed(16'($urandom)) * 2;
        m[2] = q16($urandom_range(0, 400), 0) - q16(200, 0) + $urandom_range(0, 65535);
        m[3] = $signed(16'($urandom)) * 2;
        m[4] = q16($urandom_range(0, 3), $urandom_range(0, 65535)) * (($urandom & 1) ? 1 : -1);
        m[5] = q16($urandom_range(0, 400), 0) - q16(200, 0) + $urandom_range(0, 65535);
        m[6] = 0;
        m[7] = 0;
        m[8] = q16($urandom_range(1, 2), $urandom_range(0, 65535));
      end
      1: begin
        m[0] = q16(1, $urandom_range(0, 65535));
        m[1] = 32'($signed(16'($urandom)));
        m[2] = q16($urandom_range(0, 100), 0);
        m[3] = 32'($signed(16'($urandom)));
        m[4] = q16(1, $urandom_range(0, 65535));
        m[5] = q16($urandom_range(0, 100), 0);
        m[6] = 32'($signed(10'($urandom)));
        m[7] = 32'($signed(10'($urandom)));
        m[8] = q16($urandom_range(1, 4), 0);
      end
      3: begin
        m[6] = ($urandom & 1) ? 32'h0001_0000 : 32'hffff_0000;
        m[7] = 0;
        m[8] = 0;
      end
      default: ;
    endcase
    write_coef(prb_pkg::REG_ROW0_AB, {m[0], m[1]});
    write_coef(prb_pkg::REG_ROW0_C_ROW1_A, {m[2], m[3]});
    write_coef(prb_pkg::REG_ROW1_BC, {m[4], m[5]});
    write_coef(prb_pkg::REG_ROW2_AB, {m[6], m[7]});
    write_coef(prb_pkg::REG_ROW2_C, {32'($urandom), m[8]});
  endtask

  task automatic random_rects(int count, int style);
    logic [15:0] rx, ry, rw, rh;
    int gap;
    for (int n = 0; n < count; n++) begin
      rx = 16'($urandom); ry = 16'($urandom); rw = 16'($urandom); rh = 16'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        rx = 16'($signed(11'($urandom)));
        ry = 16'($signed(11'($urandom)));
        rw = 16'($urandom_range(0, 300));
        rh = 16'($urandom_range(0, 300));
        if (style == 3) rx = 16'($urandom_range(0, 3)) - 16'd2;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (n % 64 < 16) gap = 0;
      send_rect(rx, ry, rw, rh, gap);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset
    send_rect(16'd0, 16'd0, 16'd1, 16'd1, 0);
    send_rect(16'sd10, -16'sd5, 16'd20, 16'd30, 0);
    send_rect(16'sh8000, 16'sh8000, 16'd1, 16'd1, 0);
    send_rect(16'sh8000, 16'sh8000, 16'hffff, 16'hffff, 1);
    send_rect(16'sh7ffe, 16'd0, 16'd1, 16'd1, 0);
    send_rect(16'sh7fff, 16'd0, 16'd1, 16'd1, 0);
    send_rect(16'd0, 16'sh7fff, 16'd1, 16'd1, 2);
    send_rect(16'sh8000, 16'd0, 16'hffff, 16'd1, 0);
    send_rect(16'd5, 16'd5, 16'd0, 16'd7, 0);
    send_rect(16'd5, 16'd5, 16'd7, 16'd0, 0);
    send_rect(16'd5, 16'd5, 16'd0, 16'd0, 3);
    send_rect(16'hffff, 16'hffff, 16'h8000, 16'h7fff, 0);
    drain();

    // scale by one half (y by minus one half) with an offset, then perspective, then singular divisor
    write_coef(prb_pkg::REG_ROW0_AB, {32'h0000_8000, 32'h0});
    write_coef(prb_pkg::REG_ROW1_BC, {32'hffff_8000, 32'h0003_4000});
    write_coef(prb_pkg::REG_ROW0_C_ROW1_A, {32'hfffe_c000, 32'h0});
    send_rect(16'd3, 16'd3, 16'd1, 16'd1, 0);
    send_rect(16'sh8000, 16'sh8000, 16'hffff, 16'hffff, 0);
    send_rect(-16'sd7, 16'd9, 16'd5, 16'd2, 0);
    drain();
    write_coef(prb_pkg::REG_ROW2_AB, {32'h0000_0100, 32'hffff_ff00});
    send_rect(16'd1, 16'd2, 16'd40, 16'd40, 0);
    send_rect(16'd100, 16'd0, 16'd50, 16'd50, 0);
    drain();
    write_coef(prb_pkg::REG_ROW2_AB, {32'h0001_0000, 32'h0});
    write_coef(prb_pkg::REG_ROW2_C, 64'hffff_ffff_fffe_0000);
    send_rect(16'd0, 16'd0, 16'd4, 16'd4, 0);
    send_rect(16'd5, 16'd0, 16'd4, 16'd4, 0);
    drain();

    // extreme coefficients
    write_coef(prb_pkg::REG_ROW0_AB, 64'h8000_0000_7fff_ffff);
    write_coef(prb_pkg::REG_ROW0_C_ROW1_A, 64'hffff_ffff_8000_0000);
    write_coef(prb_pkg::REG_ROW1_BC, 64'h7fff_ffff_ffff_ffff);
    write_coef(prb_pkg::REG_ROW2_AB, 64'h0);
    write_coef(prb_pkg::REG_ROW2_C, 64'h7fff_ffff);
    send_rect(16'sh8000, 16'sh7fff, 16'hffff, 16'd1, 0);
    send_rect(16'd1, 16'd1, 16'd1, 16'd1, 0);
    drain();
    write_coef(prb_pkg::REG_ROW2_C, 64'h8000_0000);
    send_rect(16'd0, 16'd0, 16'd1, 16'd1, 0);
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      load_matrix(ph % 4 == 2 ? (ph % 8 == 2 ? 2 : 3) : ph % 4);
      random_rects(50, ph % 4);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
